[rtl/core/ryuv_pkg.sv]
`timescale 1ns / 1ps

package ryuv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W     = 13;            // width of the size registers
  localparam int CNT_W     = 12;            // column and row counters
  localparam int LUMA_W    = 24;            // luma byte offset
  localparam int CADDR_W   = 25;            // chroma byte offsets
  localparam int CHR_W     = LUMA_W - 2;    // offset inside one chroma plane
  localparam int CFG_IDX_W = 2;
  localparam int NUM_W     = 15;            // numerators of the divide by 100
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = NUM_W + RECIP_W;

  // n / 100 == (n * 5243) >> 19 for every n below 25600
  localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(5243);
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = CFG_IDX_W'(2);

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic             RESET_SWAP   = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] width;   // effective width, even, 2..MAX_WIDTH
    logic [DIM_W-1:0] height;  // effective height, 1..MAX_HEIGHT
    logic             swap;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [LUMA_W-1:0] luma_addr;
    logic [CHR_W-1:0]  chroma;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic [LUMA_W-1:0]  luma_addr;
    logic [7:0]         luma_value;
    logic [CADDR_W-1:0] cb_addr;
    logic [7:0]         cb_value;
    logic [CADDR_W-1:0] cr_addr;
    logic [7:0]         cr_value;
    logic               frame_last;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] w;
    w = (v > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : v;
    w[0] = 1'b0;
    if (w < DIM_W'(2)) begin
      w = DIM_W'(2);
    end
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] h;
    h = (v > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : v;
    if (h < DIM_W'(1)) begin
      h = DIM_W'(1);
    end
    return h;
  endfunction

endpackage

[rtl/core/ryuv_ctrl.sv]
`timescale 1ns / 1ps

module ryuv_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ryuv_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           accept,
  input  logic [23:0]                    pixel_bytes,
  output ryuv_pkg::pix_t                 pix,
  output logic [ryuv_pkg::CADDR_W-1:0]   plane
);
  import ryuv_pkg::*;

  cfg_t              cfg;
  cfg_t              cfg_next;
  logic              cfg_hit;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [LUMA_W-1:0] luma;
  logic [CHR_W-1:0]  base;
  logic              col_end;
  logic              row_end;
  logic [CNT_W-1:0]  half_w;

  always_comb begin
    cfg_next = cfg;
    cfg_hit  = 1'b0;
    unique case (cfg_index)
      REG_WIDTH: begin
        cfg_next.width = clamp_width(cfg_data);
        cfg_hit        = cfg_wen;
      end
      REG_HEIGHT: begin
        cfg_next.height = clamp_height(cfg_data);
        cfg_hit         = cfg_wen;
      end
      REG_SWAP: begin
        cfg_next.swap = cfg_data[0];
        cfg_hit       = cfg_wen;
      end
      default: begin
      end
    endcase
  end

  assign col_end = ({1'b0, col} == cfg.width - DIM_W'(1));
  assign row_end = ({1'b0, row} == cfg.height - DIM_W'(1));
  assign half_w  = cfg.width[DIM_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= RESET_WIDTH;
      cfg.height <= RESET_HEIGHT;
      cfg.swap   <= RESET_SWAP;
      col        <= '0;
      row        <= '0;
      luma       <= '0;
      base       <= '0;
    end else if (cfg_hit) begin
      // any write to a known register restarts the frame
      cfg  <= cfg_next;
      col  <= '0;
      row  <= '0;
      luma <= '0;
      base <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        if (row_end) begin
          row  <= '0;
          luma <= '0;
          base <= '0;
        end else begin
          row  <= row + CNT_W'(1);
          luma <= luma + LUMA_W'(1);
          // advance the chroma row after the second row of each pair
          if (row[0]) begin
            base <= base + CHR_W'(half_w);
          end
        end
      end else begin
        col  <= col + CNT_W'(1);
        luma <= luma + LUMA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    plane <= CADDR_W'(cfg.width) * CADDR_W'(cfg.height);
  end

  always_comb begin
    pix.red       = cfg.swap ? pixel_bytes[23:16] : pixel_bytes[7:0];
    pix.green     = pixel_bytes[15:8];
    pix.blue      = cfg.swap ? pixel_bytes[7:0] : pixel_bytes[23:16];
    pix.luma_addr = luma;
    pix.chroma    = base + CHR_W'(col[CNT_W-1:1]);
    pix.last      = col_end && row_end;
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < cfg.width) else $error("column beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row} < cfg.height) else $error("row beyond frame height");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && col_end && row_end) |=> (col == '0 && row == '0 && luma == '0 && base == '0))
    else $error("position not cleared after last pixel");

  a_luma_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_hit && !(col_end && row_end)) |=> (luma == $past(luma) + LUMA_W'(1)))
    else $error("luma offset did not advance by one");

endmodule

[rtl/core/ryuv_pipe.sv]
`timescale 1ns / 1ps

module ryuv_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ryuv_pkg::pix_t               pix,
  input  logic [ryuv_pkg::CADDR_W-1:0] plane,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ryuv_pkg::res_t               res
);
  import ryuv_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]   ny;
    logic [NUM_W-1:0]   nu;
    logic [NUM_W-1:0]   nv;
    logic [LUMA_W-1:0]  luma_addr;
    logic [CADDR_W-1:0] cb_addr;
    logic [CADDR_W-1:0] cr_addr;
    logic               last;
  } num_t;

  logic        v1;
  logic        v2;
  logic        ready2;
  logic        ready3;
  pix_t        s1;
  num_t        s2;
  num_t        s2_next;
  logic [15:0] sy;
  logic [15:0] su;
  logic [15:0] sv;
  logic [PROD_W-1:0] py;
  logic [PROD_W-1:0] pu;
  logic [PROD_W-1:0] pv;

  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign in_ready = !v1 || ready2;

  // weighted sums; both chroma sums stay at or above 50, so no underflow
  always_comb begin
    sy = 16'(s1.red) * 16'd30 + 16'(s1.green) * 16'd59 + 16'(s1.blue) * 16'd11;
    su = 16'(s1.blue) * 16'd50 + 16'd12800 - 16'(s1.red) * 16'd17
         - 16'(s1.green) * 16'd33;
    sv = 16'(s1.red) * 16'd50 + 16'd12800 - 16'(s1.green) * 16'd42
         - 16'(s1.blue) * 16'd8;
    s2_next.ny        = sy[NUM_W-1:0];
    s2_next.nu        = su[NUM_W-1:0];
    s2_next.nv        = sv[NUM_W-1:0];
    s2_next.luma_addr = s1.luma_addr;
    s2_next.cb_addr   = plane + CADDR_W'(s1.chroma);
    s2_next.cr_addr   = plane + (plane >> 2) + CADDR_W'(s1.chroma);
    s2_next.last      = s1.last;
  end

  assign py = PROD_W'(s2.ny) * PROD_W'(RECIP);
  assign pu = PROD_W'(s2.nu) * PROD_W'(RECIP);
  assign pv = PROD_W'(s2.nv) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= pix;
    end
    if (ready2 && v1) begin
      s2 <= s2_next;
    end
    if (ready3 && v2) begin
      res.luma_addr  <= s2.luma_addr;
      res.luma_value <= py[RECIP_SHIFT +: 8];
      res.cb_addr    <= s2.cb_addr;
      res.cb_value   <= pu[RECIP_SHIFT +: 8];
      res.cr_addr    <= s2.cr_addr;
      res.cr_value   <= pv[RECIP_SHIFT +: 8];
      res.frame_last <= s2.last;
    end
  end

endmodule

[rtl/core/rgb_to_yuv420_planar_top.sv]
`timescale 1ns / 1ps

// Pixel stream to planar YUV 4:2:0 converter.
// The slave channel takes one pixel per request in raster order as three
// channel bytes; the master channel returns one result per pixel: luma value
// and byte offset, plus the U and V values and their offsets in the chroma
// planes (both pixels of a pair and both rows of a row pair hit the same
// chroma bytes, the last write wins). m_tlast marks the frame's last pixel.
// Three register stages, with m_tvalid raised once a pixel reaches the last;
// the block takes one pixel every cycle until a receiver stall fills it, and the
// divide by 100 is a reciprocal multiply in front of the last register stage.
// Write frame_width, frame_height and swap_red_blue through the cfg port only
// while no pixel is in flight; any write to a known register restarts the
// frame at column and row zero.
// Reset sets 640 x 480 with red and blue swapped, clears the position and
// empties the pipeline. When the receiver stalls, results hold in place and
// the three stages fill before s_tready drops.
module rgb_to_yuv420_planar_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ryuv_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // chan_byte0, chan_byte1, chan_byte2
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // luma_addr, luma_value, cb_addr, cb_value, cr_addr, cr_value, zero fill
  output logic [103:0]                   m_tdata,
  output logic                           m_tlast   // frame_last
);
  import ryuv_pkg::*;

  pix_t               pix;
  res_t               res;
  logic [CADDR_W-1:0] plane;
  logic               accept;

  assign accept = s_tvalid && s_tready;

  ryuv_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel_bytes (s_tdata),
    .pix         (pix),
    .plane       (plane)
  );

  ryuv_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pix       (pix),
    .plane     (plane),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {6'b0, res.cr_value, res.cr_addr, res.cb_value, res.cb_addr,
                    res.luma_value, res.luma_addr};
  assign m_tlast = res.frame_last;

endmodule

[tb/sv/rgb_to_yuv420_planar_top_test.sv]
`timescale 1ns / 1ps

module rgb_to_yuv420_planar_top_test;

  import ryuv_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_PIXELS = 750;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DIM_W-1:0]     reg_val;
    logic [23:0]          pix;
    logic                 typed;
    logic [7:0]           y;
    logic [7:0]           u;
    logic [7:0]           v;
  } plan_step_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [103:0]         m_tdata;
  logic                 m_tlast;

  // frame position and registers as the block should hold them
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             swap_rb;
  int unsigned      col_pos;
  int unsigned      row_pos;

  res_t       pending_yuv[$];
  plan_step_t plan[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         rx_cycle = 0;
  int         burst_left = 1;
  int         gap_due = 0;

  rgb_to_yuv420_planar_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned usable_width(logic [DIM_W-1:0] raw);
    int unsigned w;
    w = (raw > MAX_WIDTH) ? MAX_WIDTH : raw;
    w = w & ~32'd1;
    if (w < 2) begin
      w = 2;
    end
    return w;
  endfunction

  function automatic int unsigned usable_height(logic [DIM_W-1:0] raw);
    int unsigned h;
    h = (raw > MAX_HEIGHT) ? MAX_HEIGHT : raw;
    if (h < 1) begin
      h = 1;
    end
    return h;
  endfunction

  // compute the result of one pixel and advance the frame position
  task automatic convert_pixel(input logic [23:0] pix, output res_t res);
    int          r, g, b;
    int unsigned w, h, plane, chroma;
    g = pix[15:8];
    if (swap_rb) begin
      r = pix[23:16];
      b = pix[7:0];
    end else begin
      r = pix[7:0];
      b = pix[23:16];
    end
    w = usable_width(width_reg);
    h = usable_height(height_reg);
    plane = w * h;
    chroma = (row_pos >> 1) * (w >> 1) + (col_pos >> 1);
    res.luma_addr  = LUMA_W'(row_pos * w + col_pos);
    res.luma_value = 8'((30 * r + 59 * g + 11 * b) / 100);
    res.cb_addr    = CADDR_W'(plane + chroma);
    res.cb_value   = 8'((-17 * r - 33 * g + 50 * b + 12800) / 100);
    res.cr_addr    = CADDR_W'(plane + (plane >> 2) + chroma);
    res.cr_value   = 8'((50 * r - 42 * g - 8 * b + 12800) / 100);
    res.frame_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic plan_step_t pixel_row(logic [23:0] pix);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.pix = pix;
    return s;
  endfunction

  function automatic plan_step_t known_row(logic [23:0] pix, logic [7:0] y, logic [7:0] u,
                                           logic [7:0] v);
    plan_step_t s;
    s = pixel_row(pix);
    s.typed = 1'b1;
    s.y = y;
    s.u = u;
    s.v = v;
    return s;
  endfunction

  function automatic plan_step_t write_row(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    plan_step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // hold valid until the request is taken, then plan the next gap
  task automatic send_pixel(input logic [23:0] pix, input logic typed, input logic [7:0] y,
                            input logic [7:0] u, input logic [7:0] v);
    res_t res;
    if (gap_due > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_due) @(posedge clk);
      gap_due = 0;
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    convert_pixel(pix, res);
    if (typed) begin
      res.luma_value = y;
      res.cb_value = u;
      res.cr_value = v;
    end
    pending_yuv.push_back(res);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      gap_due = $urandom_range(1, 6);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_yuv.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_WIDTH: width_reg = val;
      REG_HEIGHT: height_reg = val;
      REG_SWAP: swap_rb = val[0];
      default: ;
    endcase
    // a known register restarts the frame
    if (idx != REG_UNUSED) begin
      col_pos = 0;
      row_pos = 0;
    end
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      note_mismatch(field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_yuv.size() == 0) begin
        note_mismatch("result with none pending", 32'h0, m_tdata[31:0]);
      end else begin
        want = pending_yuv.pop_front();
        check_field("luma_addr", 32'(want.luma_addr), 32'(m_tdata[23:0]));
        check_field("luma_value", 32'(want.luma_value), 32'(m_tdata[31:24]));
        check_field("cb_addr", 32'(want.cb_addr), 32'(m_tdata[56:32]));
        check_field("cb_value", 32'(want.cb_value), 32'(m_tdata[64:57]));
        check_field("cr_addr", 32'(want.cr_addr), 32'(m_tdata[89:65]));
        check_field("cr_value", 32'(want.cr_value), 32'(m_tdata[97:90]));
        check_field("frame_last", 32'(want.frame_last), 32'(m_tlast));
      end
    end
  end

  // receiver: always ready, mostly ready, mostly stalled, then a fixed duty cycle
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 97) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_cycle % 8) < 3);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          n;
    int          pause_at;
    int          random_sent;
    logic [DIM_W-1:0] w_val;
    logic [DIM_W-1:0] h_val;
    plan_step_t  s;

    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    swap_rb = RESET_SWAP;
    col_pos = 0;
    row_pos = 0;
    random_sent = 0;

    // reset state: red in byte two
    plan.push_back(known_row(24'h000000, 8'd0, 8'd128, 8'd128));
    plan.push_back(known_row(24'hFFFFFF, 8'd255, 8'd128, 8'd128));
    plan.push_back(known_row(24'hFF0000, 8'd76, 8'd84, 8'd255));
    plan.push_back(known_row(24'h0000FF, 8'd28, 8'd255, 8'd107));
    plan.push_back(known_row(24'h00FF00, 8'd150, 8'd43, 8'd20));
    plan.push_back(pixel_row(24'hA55A3C));
    // red in byte zero; chroma floors
    plan.push_back(write_row(REG_SWAP, DIM_W'(0)));
    plan.push_back(known_row(24'h0000FF, 8'd76, 8'd84, 8'd255));
    plan.push_back(known_row(24'h00FFFF, 8'd226, 8'd0, 8'd148));
    plan.push_back(known_row(24'hFFFF00, 8'd178, 8'd171, 8'd0));
    // odd width and zero height clamp to a 2 x 1 frame
    plan.push_back(write_row(REG_WIDTH, DIM_W'(3)));
    plan.push_back(write_row(REG_HEIGHT, DIM_W'(0)));
    plan.push_back(pixel_row(24'h123456));
    plan.push_back(pixel_row(24'h789ABC));
    plan.push_back(pixel_row(24'hDEF012));
    plan.push_back(pixel_row(24'h0F1E2D));
    // oversize clamps to the maximum frame
    plan.push_back(write_row(REG_WIDTH, DIM_W'(8191)));
    plan.push_back(write_row(REG_HEIGHT, DIM_W'(8191)));
    plan.push_back(pixel_row(24'hFEDCBA));
    plan.push_back(pixel_row(24'h010203));
    // unknown index: position must carry on
    plan.push_back(write_row(REG_UNUSED, DIM_W'(8191)));
    plan.push_back(pixel_row(24'h55AA55));
    plan.push_back(write_row(REG_WIDTH, DIM_W'(1)));
    plan.push_back(write_row(REG_HEIGHT, DIM_W'(2)));
    plan.push_back(write_row(REG_SWAP, DIM_W'(1)));
    plan.push_back(pixel_row(24'h808080));
    plan.push_back(pixel_row(24'h7F7F7F));
    plan.push_back(pixel_row(24'hC0FFEE));
    plan.push_back(pixel_row(24'h0BADF0));
    plan.push_back(write_row(REG_WIDTH, DIM_W'(4097)));
    plan.push_back(write_row(REG_HEIGHT, DIM_W'(4096)));
    plan.push_back(pixel_row(24'h3C5A7E));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      s = plan[i];
      if (s.kind == STEP_WRITE) begin
        drain_results();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        send_pixel(s.pix, s.typed, s.y, s.u, s.v);
      end
    end

    while (random_sent < RANDOM_PIXELS) begin
      drain_results();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: w_val = DIM_W'($urandom_range(0, 8191));
          1: w_val = DIM_W'($urandom_range(4094, 4099));
          default: w_val = DIM_W'($urandom_range(0, 13));
        endcase
        write_reg(REG_WIDTH, w_val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: h_val = DIM_W'($urandom_range(0, 8191));
          1: h_val = DIM_W'($urandom_range(4095, 4097));
          default: h_val = DIM_W'($urandom_range(0, 5));
        endcase
        write_reg(REG_HEIGHT, h_val);
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SWAP, DIM_W'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_UNUSED, DIM_W'($urandom));
      end
      n = $urandom_range(20, 90);
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
        if (k == pause_at) begin
          drain_results();
        end
        send_pixel({pick_byte(), pick_byte(), pick_byte()}, 1'b0, 8'h00, 8'h00, 8'h00);
        random_sent++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_yuv.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
